/* sv/rpf_pkg.sv */
// Package for the reflected polynomial fingerprint block.
// Holds widths, the reset polynomial, queue types and the byte fold function.
// No dependencies; every module of the block imports it.
package rpf_pkg;

  // Field widths.
  localparam int unsigned ByteW     = 8;
  localparam int unsigned FpW       = 64;
  localparam int unsigned TdataInW  = ByteW + FpW;
  localparam int unsigned TuserInW  = 3;
  localparam int unsigned TdataOutW = FpW;

  // Bit positions of the flags in the input tuser.
  localparam int unsigned UserHasByte = 0;
  localparam int unsigned UserFirst   = 1;
  localparam int unsigned UserUseSeed = 2;

  // Reset value of the polynomial and of the running value.
  localparam logic [FpW-1:0] PolyReset = 64'hA795_D0F2_9B4D_CDF8;

  // Queue between the front and the back.
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // One classified item as the back needs it.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             has_byte;
    logic             load;       // Start a new message from start_value.
    logic [FpW-1:0]   start_value;
    logic             last;
  } rpf_item_t;

  // Queue status seen by the front and by the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } rpf_fifo_status_t;

  // Fold one byte into the running value, LSB first, eight shift steps.
  function automatic logic [FpW-1:0] rpf_fold(input logic [FpW-1:0] v,
                                              input logic [ByteW-1:0] b,
                                              input logic [FpW-1:0] poly);
    logic [FpW-1:0] acc;
    logic           drop;
    acc = v ^ {{(FpW-ByteW){1'b0}}, b};
    for (int k = 0; k < ByteW; k++) begin
      drop = acc[0];
      acc  = acc >> 1;
      if (drop) begin
        acc = acc ^ poly;
      end
    end
    return acc;
  endfunction

endpackage

/* sv/reflected_poly_fingerprint_64.sv */
// Top level of the 64-bit reflected polynomial fingerprint block.
// Instantiates rpf_front, rpf_fifo and rpf_back; depends on rpf_pkg.
//
// The block takes one message byte per transaction and sustains one
// transaction per clock cycle while the queue has room; the eight xor-shift
// steps of a byte fold are done combinationally in the back stage. An accepted
// transaction enters a two-entry queue, is folded in the next cycle at the
// earliest, and a result for a transaction with tlast set appears on the master
// side in the cycle after that. The input tdata
// carries the byte and the seed, tuser carries has_byte, first and use_seed,
// and tlast marks the end of the message. A first transaction restarts from
// the polynomial or, with use_seed, from the seed. The polynomial register is
// written through the cfg channel and must only be written while the block is
// idle. After reset the polynomial and the running value both hold
// 0xA795D0F29B4DCDF8.
module reflected_poly_fingerprint_64 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel: polynomial.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rpf_pkg::FpW-1:0]       cfg_data_i,
  // Input stream.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [rpf_pkg::TdataInW-1:0]  s_axis_tdata_i,  // [7:0] data_byte, [71:8] seed_value
  input  logic [rpf_pkg::TuserInW-1:0]  s_axis_tuser_i,  // [0] has_byte, [1] first, [2] use_seed
  input  logic                          s_axis_tlast_i,  // last
  // Result stream.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [rpf_pkg::TdataOutW-1:0] m_axis_tdata_o   // [63:0] fingerprint
);
  import rpf_pkg::*;

  logic [FpW-1:0]   poly_q;
  logic             push;
  rpf_item_t        push_item;
  logic             pop;
  rpf_item_t        head;
  rpf_fifo_status_t fifo_status;

  // Polynomial register, always ready for a write.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= PolyReset;
    end else if (cfg_valid_i) begin
      poly_q <= cfg_data_i;
    end
  end

  // Front: accept and classify.
  rpf_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .poly_i          (poly_q),
    .fifo_status_i   (fifo_status),
    .push_o          (push),
    .push_item_o     (push_item)
  );

  // Queue between front and back.
  rpf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (fifo_status)
  );

  // Back: fold and deliver.
  rpf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .poly_i          (poly_q),
    .head_i          (head),
    .head_valid_i    (!fifo_status.empty),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // The queue is never popped while empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop && fifo_status.empty))
    else $error("queue popped while empty");

  // The queue is never both full and empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !(fifo_status.full && fifo_status.empty))
    else $error("queue status inconsistent");

  // A new result only follows a popped last item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(m_axis_tvalid_o) |-> $past(pop && head.last))
    else $error("result without a last transaction");

  // A held result is not overwritten by a last item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (m_axis_tvalid_o && !m_axis_tready_i) |-> !(pop && head.last))
    else $error("pending result overwritten");

endmodule

/* sv/rpf_front.sv */
// Front of the fingerprint block: accepts input transactions and classifies them.
// Resolves the starting value of a message; depends on rpf_pkg.
module rpf_front (
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [rpf_pkg::TdataInW-1:0]  s_axis_tdata_i,
  input  logic [rpf_pkg::TuserInW-1:0]  s_axis_tuser_i,
  input  logic                          s_axis_tlast_i,
  input  logic [rpf_pkg::FpW-1:0]       poly_i,
  input  rpf_pkg::rpf_fifo_status_t     fifo_status_i,
  output logic                          push_o,
  output rpf_pkg::rpf_item_t            push_item_o
);
  import rpf_pkg::*;

  // Accept whenever the queue has room.
  assign s_axis_tready_o = !fifo_status_i.full;
  assign push_o          = s_axis_tvalid_i && !fifo_status_i.full;

  // Unpack the fields and pick the starting value for a first item.
  always_comb begin
    push_item_o.data_byte   = s_axis_tdata_i[ByteW-1:0];
    push_item_o.has_byte    = s_axis_tuser_i[UserHasByte];
    push_item_o.load        = s_axis_tuser_i[UserFirst];
    push_item_o.start_value = s_axis_tuser_i[UserUseSeed] ?
                              s_axis_tdata_i[TdataInW-1:ByteW] : poly_i;
    push_item_o.last        = s_axis_tlast_i;
  end

endmodule

/* sv/rpf_fifo.sv */
// Short queue between the front and the back of the fingerprint block.
// Register array with read and write pointers; depends on rpf_pkg.
module rpf_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  rpf_pkg::rpf_item_t        push_item_i,
  input  logic                      pop_i,
  output rpf_pkg::rpf_item_t        head_o,
  output rpf_pkg::rpf_fifo_status_t status_o
);
  import rpf_pkg::*;

  rpf_item_t           mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] count_q, count_d;

  // Status from the fill count.
  assign status_o.full  = (count_q == FifoCntW'(FifoDepth));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  // Pointer and count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* sv/rpf_back.sv */
// Back of the fingerprint block: folds bytes into the running value.
// Holds the running value and the output register; depends on rpf_pkg.
module rpf_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [rpf_pkg::FpW-1:0]        poly_i,
  input  rpf_pkg::rpf_item_t             head_i,
  input  logic                           head_valid_i,
  output logic                           pop_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [rpf_pkg::TdataOutW-1:0]  m_axis_tdata_o
);
  import rpf_pkg::*;

  logic [FpW-1:0] running_q, running_d;
  logic [FpW-1:0] start_value;
  logic [FpW-1:0] next_value;
  logic           out_valid_q, out_valid_d;
  logic [FpW-1:0] out_data_q, out_data_d;
  logic           can_take;

  // A last item needs a free output slot; other items always proceed.
  assign can_take = !head_i.last || !out_valid_q || m_axis_tready_i;
  assign pop_o    = head_valid_i && can_take;

  // Load, then fold the byte; both are combinational.
  always_comb begin
    start_value = head_i.load ? head_i.start_value : running_q;
    next_value  = head_i.has_byte ? rpf_fold(start_value, head_i.data_byte, poly_i)
                                  : start_value;
  end

  // Running value and result register update.
  always_comb begin
    running_d   = running_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      running_d = next_value;
      if (head_i.last) begin
        out_valid_d = 1'b1;
        out_data_d  = next_value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= PolyReset;
      out_valid_q <= 1'b0;
    end else begin
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
